>>> design/arsh_pkg.sv
// ----------------------------------------------------------------------------
// arsh_pkg
// shared widths, limits and payload types of the residual symbol histogram
// ----------------------------------------------------------------------------
package arsh_pkg;

    localparam int ERR_W = 9;
    localparam int SYM_W = 8;
    localparam int IDX_W = 8;
    localparam int CNT_W = 16;
    localparam int TOT_W = 9;

    localparam int SYM_NUM = 1 << SYM_W;
    localparam int TABLE_DEPTH_DEF = 256;

    localparam logic [SYM_W-1:0] SYM_MAX = {SYM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
    } map_entry_t;

    typedef struct packed {
        logic [SYM_W-1:0] abs_symbol;
        logic [IDX_W-1:0] entry_index;
        logic             is_new;
        logic [CNT_W-1:0] symbol_count;
        logic [TOT_W-1:0] distinct_total;
        logic             block_done;
    } result_t;

endpackage

>>> design/arsh_if.sv
// ----------------------------------------------------------------------------
// arsh_if
// valid/ready channels for residual samples and histogram results
// ----------------------------------------------------------------------------
interface arsh_sample_if;
    import arsh_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] pred_error;
    logic                    block_end;

    modport source (output valid, output pred_error, output block_end, input ready);
    modport sink (input valid, input pred_error, input block_end, output ready);
endinterface

interface arsh_result_if;
    import arsh_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] abs_symbol;
    logic [IDX_W-1:0] entry_index;
    logic             is_new;
    logic [CNT_W-1:0] symbol_count;
    logic [TOT_W-1:0] distinct_total;
    logic             block_done;

    modport source (
        output valid, output abs_symbol, output entry_index, output is_new,
        output symbol_count, output distinct_total, output block_done,
        input ready
    );
    modport sink (
        input valid, input abs_symbol, input entry_index, input is_new,
        input symbol_count, input distinct_total, input block_done,
        output ready
    );
endinterface

>>> design/abs_residual_symbol_histogram_core.sv
// ----------------------------------------------------------------------------
// abs_residual_symbol_histogram_core
// symbol frequency table over the magnitudes of prediction residuals
// ----------------------------------------------------------------------------
// sample channel: one signed residual and a block-end mark per request
// result channel: symbol, first-seen table position, new flag, saturating
//   count, distinct-symbol total and the echoed block-end mark
// one result per sample, passed through the update stage and then the result
//   register; while the receiver does not stall, a new sample is taken
//   every cycle, the rate being set by the read-modify-write of the
//   symbol-indexed map memory (read at acceptance, written when the update
//   stage fires, with the last written entry forwarded to the next sample)
// at most TABLE_DEPTH distinct symbols are held; further new symbols are
//   dropped and reported with index, count and new flag all zero
// reset clears the per-symbol valid bits and the distinct total at once,
//   so the table is empty and usable in the first cycle after reset
// when the receiver stalls, the result register holds and the sample in the
//   update stage waits; only while that stage is empty is a sample taken
// ----------------------------------------------------------------------------
module abs_residual_symbol_histogram_core #(
    parameter int TABLE_DEPTH = arsh_pkg::TABLE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    arsh_sample_if.sink    sample,
    arsh_result_if.source  result
);
    import arsh_pkg::*;

    localparam logic [TOT_W-1:0] DEPTH_LIM = TOT_W'(TABLE_DEPTH);

    // symbol-indexed map: table position and count of each known symbol
    map_entry_t map_mem [SYM_NUM];

    logic [ERR_W-1:0] err_raw;
    logic [ERR_W-1:0] neg_err;
    logic [SYM_W-1:0] in_sym;
    logic             in_fire;

    logic             s1_valid_reg, s1_valid_next;
    logic [SYM_W-1:0] s1_sym_reg;
    logic             s1_done_reg;
    map_entry_t       rd_entry_reg;
    logic             s1_fire;

    logic             fwd_valid_reg;
    logic [SYM_W-1:0] fwd_sym_reg;
    map_entry_t       fwd_entry_reg;

    logic [SYM_NUM-1:0] known_reg, known_next;
    logic [TOT_W-1:0]   distinct_reg, distinct_next;

    logic             res_valid_reg, res_valid_next;
    result_t          res_reg, res_next;

    map_entry_t       cur_entry;
    map_entry_t       wr_entry;
    logic             map_we;
    logic             found;
    logic             full;
    logic             append;
    logic [CNT_W-1:0] cnt_inc;

    // magnitude, with the most negative residual clipped to the top symbol
    assign err_raw = sample.pred_error;
    assign neg_err = ERR_W'(~err_raw + 1'b1);

    always_comb
    begin
        if (!err_raw[ERR_W-1])
        begin
            in_sym = err_raw[SYM_W-1:0];
        end
        else if (neg_err[ERR_W-1])
        begin
            in_sym = SYM_MAX;
        end
        else
        begin
            in_sym = neg_err[SYM_W-1:0];
        end
    end

    assign s1_fire      = s1_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_fire;
    assign in_fire      = sample.valid && sample.ready;

    // update stage
    always_comb
    begin
        cur_entry = (fwd_valid_reg && (fwd_sym_reg == s1_sym_reg)) ? fwd_entry_reg
                                                                   : rd_entry_reg;
        found   = known_reg[s1_sym_reg];
        full    = (distinct_reg == DEPTH_LIM);
        append  = !found && !full;
        cnt_inc = (cur_entry.cnt == CNT_MAX) ? CNT_MAX : CNT_W'(cur_entry.cnt + 1'b1);

        map_we   = 1'b0;
        wr_entry = cur_entry;
        res_next = res_reg;
        res_next.abs_symbol = s1_sym_reg;
        res_next.block_done = s1_done_reg;

        if (found)
        begin
            map_we                  = 1'b1;
            wr_entry.idx            = cur_entry.idx;
            wr_entry.cnt            = cnt_inc;
            res_next.entry_index    = cur_entry.idx;
            res_next.is_new         = 1'b0;
            res_next.symbol_count   = cnt_inc;
            res_next.distinct_total = distinct_reg;
        end
        else if (append)
        begin
            map_we                  = 1'b1;
            wr_entry.idx            = distinct_reg[IDX_W-1:0];
            wr_entry.cnt            = CNT_W'(1);
            res_next.entry_index    = distinct_reg[IDX_W-1:0];
            res_next.is_new         = 1'b1;
            res_next.symbol_count   = CNT_W'(1);
            res_next.distinct_total = TOT_W'(distinct_reg + 1'b1);
        end
        else
        begin
            res_next.entry_index    = '0;
            res_next.is_new         = 1'b0;
            res_next.symbol_count   = '0;
            res_next.distinct_total = distinct_reg;
        end
    end

    always_comb
    begin
        known_next    = known_reg;
        distinct_next = distinct_reg;
        if (s1_fire && append)
        begin
            known_next[s1_sym_reg] = 1'b1;
            distinct_next          = TOT_W'(distinct_reg + 1'b1);
        end

        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // map memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (s1_fire && map_we)
        begin
            map_mem[s1_sym_reg] <= wr_entry;
        end
        if (in_fire)
        begin
            rd_entry_reg <= map_mem[in_sym];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sym_reg  <= in_sym;
            s1_done_reg <= sample.block_end;
        end
        if (s1_fire && map_we)
        begin
            fwd_sym_reg   <= s1_sym_reg;
            fwd_entry_reg <= wr_entry;
        end
        if (s1_fire)
        begin
            res_reg <= res_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            known_reg     <= '0;
            distinct_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            known_reg     <= known_next;
            distinct_reg  <= distinct_next;
            res_valid_reg <= res_valid_next;
            if (s1_fire && map_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.abs_symbol     = res_reg.abs_symbol;
    assign result.entry_index    = res_reg.entry_index;
    assign result.is_new         = res_reg.is_new;
    assign result.symbol_count   = res_reg.symbol_count;
    assign result.distinct_total = res_reg.distinct_total;
    assign result.block_done     = res_reg.block_done;

    // checks
    a_distinct_limit: assert property (@(posedge clk) disable iff (!rst_n)
        distinct_reg <= DEPTH_LIM)
        else $error("distinct total beyond table depth");

    a_known_matches_total: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(known_reg) == 32'(distinct_reg))
        else $error("valid bits disagree with distinct total");

    a_append_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && append |=> distinct_reg == TOT_W'($past(distinct_reg) + 1'b1))
        else $error("append did not raise distinct total");

    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && found |=> res_valid_reg && res_reg.symbol_count != '0
            && !res_reg.is_new)
        else $error("known symbol gave a zero count or new flag");

endmodule
